// ===== rtl/chs_pkg.sv =====
// Shared types and constants of the chained hash set engine.
// No dependencies; imported by every module of the block but chs_ram.
package chs_pkg;

	localparam int MAX_BUCKETS_DEF   = 256;
	localparam int CHAIN_DEPTH_DEF   = 8;
	localparam int MAX_KEY_BYTES_DEF = 15;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_W     = 9;
	localparam int KEY_LO_W  = 64;
	localparam int KEY_HI_W  = 56;
	localparam int KEY_W     = KEY_LO_W + KEY_HI_W;
	localparam int LEN_W     = 4;
	localparam int IDX_W     = 8;
	localparam int BKT_MAX_W = 16;
	localparam int SLOT_W    = KEY_W + LEN_W;

	// Hash arithmetic: residues below 2^30, working sum below 2^38.
	localparam int HASH_W = 30;
	localparam int ACC_W  = 38;
	localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
	localparam logic [8:0]        HASH_MULT  = 9'd263;
	// 2^30 mod prime, used to fold the upper bits back in.
	localparam logic [26:0]       FOLD_C     = 27'd73741817;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_DEL  = 2'd1;
	localparam logic [1:0] ACT_FIND = 2'd2;
	localparam logic [1:0] ACT_CHK  = 2'd3;

	localparam logic [1:0] KIND_FIND  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_OVF   = 2'd3;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [1:0]           action;
		logic [KEY_HI_W-1:0]  key_high;
		logic [KEY_LO_W-1:0]  key_low;
		logic [LEN_W-1:0]     key_len;
		logic [BKT_MAX_W-1:0] bucket;
		logic                 skip;
	} req_t;

endpackage

// ===== rtl/chs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/chs_front.sv =====
// Front end: accept requests, mask keys, hash and reduce to a bucket.
// Depends on chs_pkg.
module chs_front #(
	parameter int MAX_BUCKETS   = chs_pkg::MAX_BUCKETS_DEF,
	parameter int MAX_KEY_BYTES = chs_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [chs_pkg::CFG_W-1:0]     modulus,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [chs_pkg::KEY_LO_W-1:0]  key_low,
	input  logic [chs_pkg::KEY_HI_W-1:0]  key_high,
	input  logic [chs_pkg::LEN_W-1:0]     key_length,
	input  logic [chs_pkg::IDX_W-1:0]     bucket_index,
	output logic                          q_push,
	input  logic                          q_full,
	output chs_pkg::req_t                 q_req
);
	import chs_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_HASH = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]         state_q;
	req_t               req_q;
	logic [KEY_W-1:0]   key_q;
	logic [ACC_W-1:0]   acc_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [HASH_W-1:0]  h_q;
	logic [CFG_W:0]     rem_q;
	logic [4:0]         bit_q;

	logic [CFG_W-1:0]   live;
	logic [LEN_W-1:0]   len_sat;
	logic [KEY_W-1:0]   key_in;
	logic [KEY_W-1:0]   key_mask;
	logic [HASH_W-1:0]  acc_red;
	logic [LEN_W-1:0]   byte_sel;
	logic [7:0]         cur_byte;
	logic [CFG_W:0]     rem_sh;

	always_comb begin
		if (modulus == '0) begin
			live = CFG_W'(1);
		end else if (32'(modulus) > MAX_BUCKETS) begin
			live = CFG_W'(MAX_BUCKETS);
		end else begin
			live = modulus;
		end
		len_sat = (32'(key_length) > MAX_KEY_BYTES) ? LEN_W'(MAX_KEY_BYTES) : key_length;
		key_in  = {key_high, key_low};
		for (int i = 0; i < KEY_W / 8; i++) begin
			key_mask[8*i +: 8] = (i < 32'(len_sat)) ? 8'hFF : 8'h00;
		end
		acc_red  = (acc_q[HASH_W-1:0] >= HASH_PRIME) ? acc_q[HASH_W-1:0] - HASH_PRIME
			: acc_q[HASH_W-1:0];
		byte_sel = cnt_q - LEN_W'(1);
		cur_byte = key_q[8*byte_sel +: 8];
		rem_sh   = {rem_q[CFG_W-1:0], h_q[HASH_W-1]};
	end

	assign in_stall = (state_q != F_IDLE);
	assign q_push   = (state_q == F_PUSH) && !q_full;
	assign q_req    = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						req_q.action   <= action;
						req_q.key_low  <= key_in[KEY_LO_W-1:0] & key_mask[KEY_LO_W-1:0];
						req_q.key_high <= key_in[KEY_W-1:KEY_LO_W] & key_mask[KEY_W-1:KEY_LO_W];
						req_q.key_len  <= len_sat;
						key_q          <= key_in & key_mask;
						acc_q          <= '0;
						cnt_q          <= len_sat;
						if (action == ACT_CHK) begin
							req_q.bucket <= BKT_MAX_W'(bucket_index);
							req_q.skip   <= ({1'b0, bucket_index} >= live);
							state_q      <= F_PUSH;
						end else if (len_sat == '0) begin
							req_q.bucket <= '0;
							req_q.skip   <= 1'b1;
							state_q      <= F_PUSH;
						end else begin
							req_q.skip <= 1'b0;
							state_q    <= F_HASH;
						end
					end
				end
				F_HASH: begin
					// Fold the bits above 2^30 back in until the sum is small.
					if (acc_q[ACC_W-1:HASH_W] != '0) begin
						acc_q <= ACC_W'(acc_q[ACC_W-1:HASH_W]) * ACC_W'(FOLD_C)
							+ ACC_W'(acc_q[HASH_W-1:0]);
					end else if (cnt_q == '0) begin
						h_q     <= acc_red;
						rem_q   <= '0;
						bit_q   <= 5'(HASH_W);
						state_q <= F_DIV;
					end else begin
						acc_q <= ACC_W'(acc_red) * ACC_W'(HASH_MULT) + ACC_W'(cur_byte);
						cnt_q <= byte_sel;
					end
				end
				F_DIV: begin
					if (bit_q == '0) begin
						req_q.bucket <= BKT_MAX_W'(rem_q);
						state_q      <= F_PUSH;
					end else begin
						rem_q <= (rem_sh >= {1'b0, live}) ? rem_sh - {1'b0, live} : rem_sh;
						h_q   <= {h_q[HASH_W-2:0], 1'b0};
						bit_q <= bit_q - 5'd1;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/chs_queue.sv =====
// Small request queue between front and back.
// Depends on chs_pkg.
module chs_queue #(
	parameter int DEPTH = chs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  chs_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output chs_pkg::req_t head,
	output logic          empty
);
	import chs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// ===== rtl/chs_back.sv =====
// Back end: chain walk, insert, delete with shift, and the result register.
// Depends on chs_pkg and chs_ram.
module chs_back #(
	parameter int MAX_BUCKETS = chs_pkg::MAX_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chs_pkg::req_t                 q_head,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic                          found,
	output logic [chs_pkg::KEY_LO_W-1:0]  entry_low,
	output logic [chs_pkg::KEY_HI_W-1:0]  entry_high,
	output logic [chs_pkg::LEN_W-1:0]     entry_length,
	output logic                          last
);
	import chs_pkg::*;

	localparam int BW      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int KW      = $clog2(CHAIN_DEPTH + 1);
	localparam int SLOTS   = MAX_BUCKETS * CHAIN_DEPTH;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_FILL = 4'd1;
	localparam logic [3:0] B_SKIP = 4'd2;
	localparam logic [3:0] B_LRD  = 4'd3;
	localparam logic [3:0] B_LOUT = 4'd4;
	localparam logic [3:0] B_SRD  = 4'd5;
	localparam logic [3:0] B_SCMP = 4'd6;
	localparam logic [3:0] B_DONE = 4'd7;
	localparam logic [3:0] B_SHRD = 4'd8;
	localparam logic [3:0] B_SHWR = 4'd9;

	logic [3:0]             state_q;
	req_t                   cur_q;
	logic [KW-1:0]          fill_q;
	logic [KW-1:0]          k_q;
	logic                   hit_q;
	logic [MAX_BUCKETS-1:0] valid_q;
	logic                   out_valid_q;

	logic [BW-1:0]          bkt;
	logic [BW-1:0]          fill_raddr;
	logic [KW-1:0]          fill_rd;
	logic [KW-1:0]          fill_now;
	logic                   fill_we;
	logic [KW-1:0]          fill_wdata;
	logic [KW-1:0]          rk;
	logic [SLOT_AW-1:0]     base;
	logic [SLOT_AW-1:0]     slot_raddr;
	logic [SLOT_W-1:0]      slot_rd;
	logic                   slot_we;
	logic [SLOT_AW-1:0]     slot_waddr;
	logic [SLOT_W-1:0]      slot_wdata;
	logic                   match;
	logic                   shift_end;
	logic                   can_emit;
	logic                   emit;
	logic [1:0]             e_kind;
	logic                   e_found;
	logic [SLOT_W-1:0]      e_slot;
	logic                   e_last;

	assign bkt        = cur_q.bucket[BW-1:0];
	assign fill_raddr = (state_q == B_IDLE) ? q_head.bucket[BW-1:0] : bkt;
	assign fill_now   = valid_q[bkt] ? fill_rd : '0;
	assign rk         = (state_q == B_SHRD) ? k_q + KW'(1) : k_q;
	assign base       = SLOT_AW'(32'(bkt) * CHAIN_DEPTH);
	assign slot_raddr = base + SLOT_AW'(rk);
	assign match      = (slot_rd == {cur_q.key_len, cur_q.key_high, cur_q.key_low});
	assign shift_end  = ((KW+1)'(k_q) + (KW+1)'(1)) >= (KW+1)'(fill_q);
	assign can_emit   = !out_valid_q || !out_stall;
	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;

	chs_ram #(.WIDTH(KW), .DEPTH(MAX_BUCKETS)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (bkt),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rd)
	);

	chs_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	// Result selection and memory writes.
	always_comb begin
		emit       = 1'b0;
		e_kind     = KIND_FIND;
		e_found    = 1'b0;
		e_slot     = '0;
		e_last     = 1'b1;
		fill_we    = 1'b0;
		fill_wdata = '0;
		slot_we    = 1'b0;
		slot_waddr = base + SLOT_AW'(k_q);
		slot_wdata = slot_rd;
		unique case (state_q)
			B_SKIP: begin
				if (cur_q.action == ACT_CHK) begin
					emit   = 1'b1;
					e_kind = KIND_EMPTY;
				end else if (cur_q.action == ACT_FIND) begin
					emit = 1'b1;
				end
			end
			B_FILL: begin
				if (cur_q.action == ACT_CHK && fill_now == '0) begin
					emit   = 1'b1;
					e_kind = KIND_EMPTY;
				end
			end
			B_LOUT: begin
				emit   = 1'b1;
				e_kind = KIND_ENTRY;
				e_slot = slot_rd;
				e_last = (k_q == '0);
			end
			B_DONE: begin
				if (cur_q.action == ACT_FIND) begin
					emit    = 1'b1;
					e_found = hit_q;
				end else if (cur_q.action == ACT_ADD && !hit_q) begin
					if (32'(fill_q) >= CHAIN_DEPTH) begin
						emit   = 1'b1;
						e_kind = KIND_OVF;
					end else begin
						slot_we    = 1'b1;
						slot_waddr = base + SLOT_AW'(fill_q);
						slot_wdata = {cur_q.key_len, cur_q.key_high, cur_q.key_low};
						fill_we    = 1'b1;
						fill_wdata = fill_q + KW'(1);
					end
				end
			end
			B_SHRD: begin
				if (shift_end) begin
					fill_we    = 1'b1;
					fill_wdata = fill_q - KW'(1);
				end
			end
			B_SHWR: begin
				slot_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit && can_emit) begin
			kind         <= e_kind;
			found        <= e_found;
			entry_low    <= e_slot[KEY_LO_W-1:0];
			entry_high   <= e_slot[KEY_W-1:KEY_LO_W];
			entry_length <= e_slot[SLOT_W-1:KEY_W];
			last         <= e_last;
		end
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
			k_q         <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (emit && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fill_we) begin
				valid_q[bkt] <= 1'b1;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= q_head.skip ? B_SKIP : B_FILL;
					end
				end
				B_SKIP: begin
					if (!emit || can_emit) begin
						state_q <= B_IDLE;
					end
				end
				B_FILL: begin
					fill_q <= fill_now;
					hit_q  <= 1'b0;
					if (cur_q.action == ACT_CHK) begin
						if (fill_now == '0) begin
							if (can_emit) begin
								state_q <= B_IDLE;
							end
						end else begin
							k_q     <= fill_now - KW'(1);
							state_q <= B_LRD;
						end
					end else begin
						k_q     <= '0;
						state_q <= B_SRD;
					end
				end
				B_LRD: state_q <= B_LOUT;
				B_LOUT: begin
					if (can_emit) begin
						if (k_q == '0) begin
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_q - KW'(1);
							state_q <= B_LRD;
						end
					end
				end
				B_SRD: begin
					state_q <= (k_q == fill_q) ? B_DONE : B_SCMP;
				end
				B_SCMP: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= B_DONE;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= B_SRD;
					end
				end
				B_DONE: begin
					if (!emit || can_emit) begin
						state_q <= (cur_q.action == ACT_DEL && hit_q) ? B_SHRD : B_IDLE;
					end
				end
				B_SHRD: begin
					state_q <= shift_end ? B_IDLE : B_SHWR;
				end
				B_SHWR: begin
					k_q     <= k_q + KW'(1);
					state_q <= B_SHRD;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/chained_hash_set_engine.sv =====
// The front hashes each key byte serially (multiply and fold), then runs a serial bucket division
// and the push; the back then scans the chain slot by slot.
// The front takes no new request until the last one is pushed; checks and zero-length keys skip
// the hash and divider. A delete then shifts the later slots down, and a check lists each entry.
// Front and back overlap across a 2-entry queue; results leave through one output register.
// Reset (arst_n low, asynchronous) empties every chain at once and sets the modulus to 256.
module chained_hash_set_engine #(
	parameter int MAX_BUCKETS   = chs_pkg::MAX_BUCKETS_DEF,
	parameter int CHAIN_DEPTH   = chs_pkg::CHAIN_DEPTH_DEF,
	parameter int MAX_KEY_BYTES = chs_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [chs_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [chs_pkg::KEY_LO_W-1:0]  key_low,
	input  logic [chs_pkg::KEY_HI_W-1:0]  key_high,
	input  logic [chs_pkg::LEN_W-1:0]     key_length,
	input  logic [chs_pkg::IDX_W-1:0]     bucket_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic                          found,
	output logic [chs_pkg::KEY_LO_W-1:0]  entry_low,
	output logic [chs_pkg::KEY_HI_W-1:0]  entry_high,
	output logic [chs_pkg::LEN_W-1:0]     entry_length,
	output logic                          last
);
	import chs_pkg::*;

	logic [CFG_W-1:0] modulus_q;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	req_t             push_req;
	req_t             head_req;

	// Bucket modulus register; the user must write it only while the engine is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= CFG_W'(256);
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	// Front: accept a request, hash the key, reduce to a bucket.
	chs_front #(
		.MAX_BUCKETS   (MAX_BUCKETS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.modulus      (modulus_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key_low      (key_low),
		.key_high     (key_high),
		.key_length   (key_length),
		.bucket_index (bucket_index),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_req        (push_req)
	);

	// Decouple hashing from chain work.
	chs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_req),
		.empty    (q_empty)
	);

	// Back: walk, insert, delete with shift; drive results.
	chs_back #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (head_req),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.found        (found),
		.entry_low    (entry_low),
		.entry_high   (entry_high),
		.entry_length (entry_length),
		.last         (last)
	);
endmodule

// ===== rtl/chs_checker.sv =====
// Port-level checks of the chained hash set engine results.
// Depends on chs_pkg; bound to chained_hash_set_engine.
module chs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    kind,
	input logic                          found,
	input logic [chs_pkg::KEY_LO_W-1:0]  entry_low,
	input logic [chs_pkg::LEN_W-1:0]     entry_length,
	input logic                          last
);
	import chs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(entry_low))
		else $error("stalled result changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ENTRY |-> last && entry_length == '0)
		else $error("non-entry result not final or carries a key");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_FIND |-> !found)
		else $error("found set outside a find answer");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ENTRY |-> entry_length != '0)
		else $error("chain entry with zero length");
endmodule

bind chained_hash_set_engine chs_checker u_chs_checker (.*);
